// ===== sv/tsr_pkg.sv =====
`default_nettype none
package tsr_pkg;

  // Default table size and the reset values of the two registers.
  localparam int          SLOTS_DEF    = 32;
  localparam logic [5:0]  SIU_RST      = 6'd32;
  localparam logic [63:0] START_ID_RST = 64'd1;
  localparam logic [63:0] ALL_ONES     = '1;

  // Register indexes of the configuration port.
  localparam logic CFG_SLOTS_IN_USE = 1'b0;
  localparam logic CFG_START_ID     = 1'b1;

  // Memory words: id and owner in one, commit number and stamp in the other.
  localparam int ID_W    = 64;
  localparam int OWNER_W = 32;
  localparam int A_W     = ID_W + OWNER_W;
  localparam int B_W     = 2 * ID_W;

  typedef enum logic [3:0] {
    CMD_BEGIN      = 4'd0,
    CMD_ALLOCATE   = 4'd1,
    CMD_ASSIGN     = 4'd2,
    CMD_ASSIGN_NEW = 4'd3,
    CMD_END        = 4'd4,
    CMD_RELEASE    = 4'd5,
    CMD_SNAPSHOT   = 4'd6,
    CMD_READ_VIEW  = 4'd7,
    CMD_INIT       = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ERROR     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // One result beat as it travels from the controller to the output register.
  typedef struct packed {
    status_t     status;
    logic [63:0] txn_id;
    logic [4:0]  slot;
    logic [63:0] gen;
    logic [63:0] commit_no;
    logic [5:0]  tally;
    logic [63:0] next_id;
    logic [63:0] lowest;
    logic [63:0] listed_id;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/tsr_ram.sv =====
`default_nettype none
module tsr_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/tsr_ctrl.sv =====
`default_nettype none
module tsr_ctrl import tsr_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW   = $clog2(SLOTS + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  output logic                in_ready,
  input  wire logic [3:0]     in_command,
  input  wire logic [31:0]    in_owner,
  input  wire logic [63:0]    in_txn_id,
  input  wire logic [63:0]    in_commit_no,
  input  wire logic [5:0]     in_slot,
  input  wire logic [63:0]    in_slot_gen,
  input  wire logic [5:0]     in_capacity,
  input  wire logic [5:0]     slots_in_use,
  input  wire logic [63:0]    start_id,
  output logic                res_valid,
  output res_t                res,
  input  wire logic           res_ready,
  output logic [IW-1:0]       raddr,
  output logic [IW-1:0]       waddr,
  output logic                a_we,
  output logic [A_W-1:0]      a_wdata,
  output logic                b_we,
  output logic [B_W-1:0]      b_wdata,
  input  wire logic [A_W-1:0] a_rdata,
  input  wire logic [B_W-1:0] b_rdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_END_RD, S_END_CHK, S_REL, S_OLDEST, S_COUNT, S_PICK, S_EMIT
  } state_t;

  localparam logic [6:0] SLOTS7 = 7'(SLOTS);

  state_t            state_r, state_nxt;
  logic [SLOTS-1:0]  active_r, active_nxt;
  logic [63:0]       id_ctr_r, id_ctr_nxt;
  logic [63:0]       gg_r, gg_nxt;
  logic [CW-1:0]     total_r, total_nxt;
  logic [63:0]       oldest_r, oldest_nxt;
  logic              rd_pend_r, rd_pend_nxt;

  logic [3:0]        cmd_r, cmd_nxt;
  logic [31:0]       owner_r, owner_nxt;
  logic [63:0]       txn_r, txn_nxt;
  logic [63:0]       commit_r, commit_nxt;
  logic [5:0]        slot_r, slot_nxt;
  logic [63:0]       gen_r, gen_nxt;
  logic [5:0]        cap_r, cap_nxt;
  logic [CW-1:0]     scan_addr_r, scan_addr_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [63:0]       best_r, best_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [63:0]       prev_r, prev_nxt;
  logic [CW-1:0]     emitted_r, emitted_nxt;
  logic [CW-1:0]     rel_r, rel_nxt;
  res_t              res_r, res_nxt;

  logic [CW-1:0]     n_cnt;
  logic              scan_state, issue, scan_done;
  logic              free_found;
  logic [IW-1:0]     free_idx;
  logic [63:0]       d_txn, d_commit, d_stamp;
  logic [31:0]       d_owner;
  logic              d_act;

  assign n_cnt = (7'(slots_in_use) > SLOTS7) ? CW'(SLOTS) : CW'(slots_in_use);

  assign d_txn    = a_rdata[A_W-1:OWNER_W];
  assign d_owner  = a_rdata[OWNER_W-1:0];
  assign d_commit = b_rdata[B_W-1:ID_W];
  assign d_stamp  = b_rdata[ID_W-1:0];
  assign d_act    = active_r[rd_idx_r];

  // Scan engine: one address issued a cycle, its data handled in the cycle after.
  assign scan_state = (state_r == S_FIND) || (state_r == S_REL) || (state_r == S_OLDEST) ||
                      (state_r == S_COUNT) || (state_r == S_PICK);
  assign issue      = scan_state && (scan_addr_r < n_cnt);
  assign scan_done  = !rd_pend_r && (scan_addr_r >= n_cnt);
  assign raddr      = (state_r == S_END_RD) ? slot_r[IW-1:0] : scan_addr_r[IW-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_EMIT);
  assign res       = res_r;

  // Lowest free slot among the scanned ones, for begin.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if ((CW'(i) < n_cnt) && !active_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Command sequencing and the read-modify-write of the slot table.
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    id_ctr_nxt    = id_ctr_r;
    gg_nxt        = gg_r;
    total_nxt     = total_r;
    oldest_nxt    = oldest_r;
    rd_pend_nxt   = rd_pend_r;
    cmd_nxt       = cmd_r;
    owner_nxt     = owner_r;
    txn_nxt       = txn_r;
    commit_nxt    = commit_r;
    slot_nxt      = slot_r;
    gen_nxt       = gen_r;
    cap_nxt       = cap_r;
    scan_addr_nxt = scan_addr_r;
    rd_idx_nxt    = rd_idx_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    emitted_nxt   = emitted_r;
    rel_nxt       = rel_r;
    res_nxt       = res_r;
    a_we          = 1'b0;
    b_we          = 1'b0;
    waddr         = '0;
    a_wdata       = '0;
    b_wdata       = '0;

    if (scan_state) begin
      rd_pend_nxt = issue;
      if (issue) begin
        rd_idx_nxt    = scan_addr_r[IW-1:0];
        scan_addr_nxt = CW'(scan_addr_r + 1'b1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = in_command;
          owner_nxt     = in_owner;
          txn_nxt       = in_txn_id;
          commit_nxt    = in_commit_no;
          slot_nxt      = in_slot;
          gen_nxt       = in_slot_gen;
          cap_nxt       = in_capacity;
          res_nxt       = '0;
          res_nxt.last  = 1'b1;
          res_nxt.status = ST_OK;
          state_nxt     = S_EMIT;
          scan_addr_nxt = '0;
          rd_pend_nxt   = 1'b0;
          case (in_command)
            CMD_BEGIN: begin
              if (in_owner == '0 || id_ctr_r == ALL_ONES) begin
                res_nxt.status = ST_ERROR;
              end else if (!free_found) begin
                res_nxt.status = ST_FULL;
              end else if (gg_r == ALL_ONES) begin
                res_nxt.status = ST_ERROR;
              end else begin
                gg_nxt     = gg_r + 64'd1;
                a_we       = 1'b1;
                b_we       = 1'b1;
                waddr      = free_idx;
                a_wdata    = {id_ctr_r, in_owner};
                b_wdata    = {ALL_ONES, gg_r + 64'd1};
                active_nxt[free_idx] = 1'b1;
                total_nxt  = CW'(total_r + 1'b1);
                if (oldest_r == '0 || id_ctr_r < oldest_r) begin
                  oldest_nxt = id_ctr_r;
                end
                res_nxt.txn_id = id_ctr_r;
                res_nxt.slot   = 5'(free_idx);
                res_nxt.gen    = gg_r + 64'd1;
                id_ctr_nxt     = id_ctr_r + 64'd1;
              end
            end
            CMD_ALLOCATE: begin
              if (id_ctr_r == ALL_ONES) begin
                res_nxt.status = ST_ERROR;
              end else begin
                res_nxt.txn_id = id_ctr_r;
                id_ctr_nxt     = id_ctr_r + 64'd1;
              end
            end
            CMD_ASSIGN: begin
              if (in_txn_id == '0 || in_commit_no == '0 || in_commit_no == ALL_ONES) begin
                res_nxt.status = ST_ERROR;
              end else begin
                state_nxt = S_FIND;
              end
            end
            CMD_ASSIGN_NEW: begin
              if (in_txn_id == '0) begin
                res_nxt.status = ST_ERROR;
              end else begin
                state_nxt = S_FIND;
              end
            end
            CMD_END: begin
              if (in_slot_gen == '0) begin
                res_nxt.status = ST_ERROR;
              end else if (7'(in_slot) >= 7'(n_cnt) || !active_r[in_slot[IW-1:0]]) begin
                res_nxt.status = ST_NOT_FOUND;
              end else begin
                state_nxt = S_END_RD;
              end
            end
            CMD_RELEASE: begin
              if (in_owner == '0 || gg_r > (ALL_ONES - 64'(total_r))) begin
                res_nxt.status = ST_ERROR;
              end else begin
                rel_nxt   = '0;
                state_nxt = S_REL;
              end
            end
            CMD_SNAPSHOT, CMD_READ_VIEW: begin
              cnt_nxt   = '0;
              best_nxt  = id_ctr_r;
              state_nxt = S_COUNT;
            end
            CMD_INIT: begin
              if (start_id == '0 || slots_in_use == '0) begin
                res_nxt.status = ST_ERROR;
              end else begin
                active_nxt = '0;
                id_ctr_nxt = start_id;
                gg_nxt     = '0;
                total_nxt  = '0;
                oldest_nxt = '0;
              end
            end
            default: begin
              res_nxt.status = ST_ERROR;
            end
          endcase
        end
      end

      S_FIND: begin
        if (rd_pend_r && d_act && d_txn == txn_r) begin
          state_nxt = S_EMIT;
          waddr     = rd_idx_r;
          if (cmd_r == CMD_ASSIGN) begin
            b_we    = 1'b1;
            b_wdata = {commit_r, d_stamp};
          end else if (id_ctr_r == ALL_ONES) begin
            res_nxt.status = ST_ERROR;
          end else begin
            b_we              = 1'b1;
            b_wdata           = {id_ctr_r, d_stamp};
            res_nxt.commit_no = id_ctr_r;
            id_ctr_nxt        = id_ctr_r + 64'd1;
          end
        end else if (scan_done) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end
      end

      S_END_RD: begin
        state_nxt = S_END_CHK;
      end

      // Stamp of the addressed slot is now on the read port.
      S_END_CHK: begin
        if (d_stamp != gen_r) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end else if (gg_r == ALL_ONES || total_r == '0) begin
          res_nxt.status = ST_ERROR;
          state_nxt      = S_EMIT;
        end else begin
          gg_nxt     = gg_r + 64'd1;
          b_we       = 1'b1;
          waddr      = slot_r[IW-1:0];
          b_wdata    = {64'd0, gg_r + 64'd1};
          active_nxt[slot_r[IW-1:0]] = 1'b0;
          total_nxt  = CW'(total_r - 1'b1);
          best_nxt   = '0;
          scan_addr_nxt = '0;
          rd_pend_nxt   = 1'b0;
          state_nxt  = S_OLDEST;
        end
      end

      S_REL: begin
        if (rd_pend_r && d_act && d_owner == owner_r && total_r != '0) begin
          gg_nxt     = gg_r + 64'd1;
          b_we       = 1'b1;
          waddr      = rd_idx_r;
          b_wdata    = {64'd0, gg_r + 64'd1};
          active_nxt[rd_idx_r] = 1'b0;
          total_nxt  = CW'(total_r - 1'b1);
          rel_nxt    = CW'(rel_r + 1'b1);
        end else if (scan_done) begin
          res_nxt.tally = 6'(rel_r);
          if (rel_r != '0) begin
            best_nxt      = '0;
            scan_addr_nxt = '0;
            state_nxt     = S_OLDEST;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      // Oldest active id among the scanned slots; zero when none.
      S_OLDEST: begin
        if (rd_pend_r) begin
          if (d_act && (best_r == '0 || d_txn < best_r)) begin
            best_nxt = d_txn;
          end
        end else if (scan_done) begin
          oldest_nxt = best_r;
          state_nxt  = S_EMIT;
        end
      end

      // First pass of a listing: count active slots and find the lowest commit.
      S_COUNT: begin
        if (rd_pend_r) begin
          if (d_act) begin
            cnt_nxt = CW'(cnt_r + 1'b1);
            if (d_commit < best_r) begin
              best_nxt = d_commit;
            end
          end
        end else if (scan_done) begin
          res_nxt.tally   = 6'(total_r);
          res_nxt.next_id = id_ctr_r;
          res_nxt.lowest  = (cmd_r == CMD_READ_VIEW) ? best_r : oldest_r;
          state_nxt       = S_EMIT;
          if (7'(total_r) > 7'(cap_r)) begin
            res_nxt.status = ST_FULL;
          end else if (cnt_r != total_r) begin
            res_nxt        = '0;
            res_nxt.status = ST_ERROR;
            res_nxt.last   = 1'b1;
          end else if (cnt_r != '0) begin
            res_nxt.last  = 1'b0;
            prev_nxt      = '0;
            emitted_nxt   = '0;
            best_nxt      = ALL_ONES;
            found_nxt     = 1'b0;
            scan_addr_nxt = '0;
            state_nxt     = S_PICK;
          end
        end
      end

      // Each further pass picks the smallest id above the one listed last.
      S_PICK: begin
        if (rd_pend_r) begin
          if (d_act && d_txn > prev_r && (!found_r || d_txn < best_r)) begin
            best_nxt  = d_txn;
            found_nxt = 1'b1;
          end
        end else if (scan_done) begin
          res_nxt.listed_id = best_r;
          res_nxt.last      = (CW'(emitted_r + 1'b1) == cnt_r);
          prev_nxt          = best_r;
          emitted_nxt       = CW'(emitted_r + 1'b1);
          state_nxt         = S_EMIT;
        end
      end

      S_EMIT: begin
        if (res_ready) begin
          if (res_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            best_nxt      = ALL_ONES;
            found_nxt     = 1'b0;
            scan_addr_nxt = '0;
            rd_pend_nxt   = 1'b0;
            state_nxt     = S_PICK;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      active_r  <= '0;
      id_ctr_r  <= START_ID_RST;
      gg_r      <= '0;
      total_r   <= '0;
      oldest_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      id_ctr_r  <= id_ctr_nxt;
      gg_r      <= gg_nxt;
      total_r   <= total_nxt;
      oldest_r  <= oldest_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // Command fields, scan work registers and the pending result.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    owner_r     <= owner_nxt;
    txn_r       <= txn_nxt;
    commit_r    <= commit_nxt;
    slot_r      <= slot_nxt;
    gen_r       <= gen_nxt;
    cap_r       <= cap_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_r      <= best_nxt;
    found_r     <= found_nxt;
    cnt_r       <= cnt_nxt;
    prev_r      <= prev_nxt;
    emitted_r   <= emitted_nxt;
    rel_r       <= rel_nxt;
    res_r       <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/transaction_slot_registry_unit.sv =====
`default_nettype none
// Begin, allocate and initialize give their result without a table scan.
// Assign, release, snapshot and read-view scan the table one slot a cycle through the
// memory read port; end, and a release that frees a slot, add a pass for the oldest id,
// and a listing of k ids takes (k+1) passes.
// One command is in work at a time; a new beat is taken while the last result waits.
// Synchronous reset clears the active flags and counters; memory contents need no clearing.
module transaction_slot_registry_unit import tsr_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_command,
  input  wire logic [31:0] in_owner,
  input  wire logic [63:0] in_txn_id,
  input  wire logic [63:0] in_commit_no,
  input  wire logic [5:0]  in_slot,
  input  wire logic [63:0] in_slot_gen,
  input  wire logic [5:0]  in_capacity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [63:0]      out_txn_id,
  output logic [4:0]       out_slot,
  output logic [63:0]      out_gen,
  output logic [63:0]      out_commit_no,
  output logic [5:0]       out_tally,
  output logic [63:0]      out_next_id,
  output logic [63:0]      out_lowest,
  output logic [63:0]      out_listed_id,
  output logic             out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [5:0]     siu_r;
  logic [63:0]    start_id_r;
  logic           out_valid_r;
  res_t           out_r;
  res_t           res;
  logic           res_valid, res_ready;
  logic [IW-1:0]  raddr, waddr;
  logic           a_we, b_we;
  logic [A_W-1:0] a_wdata, a_rdata;
  logic [B_W-1:0] b_wdata, b_rdata;

  // Configuration registers; a write is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r      <= SIU_RST;
      start_id_r <= START_ID_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SLOTS_IN_USE: siu_r      <= cfg_data[5:0];
        CFG_START_ID:     start_id_r <= cfg_data;
        default:          siu_r      <= siu_r;
      endcase
    end
  end

  tsr_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_valid && in_ready),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_owner     (in_owner),
    .in_txn_id    (in_txn_id),
    .in_commit_no (in_commit_no),
    .in_slot      (in_slot),
    .in_slot_gen  (in_slot_gen),
    .in_capacity  (in_capacity),
    .slots_in_use (siu_r),
    .start_id     (start_id_r),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready),
    .raddr        (raddr),
    .waddr        (waddr),
    .a_we         (a_we),
    .a_wdata      (a_wdata),
    .b_we         (b_we),
    .b_wdata      (b_wdata),
    .a_rdata      (a_rdata),
    .b_rdata      (b_rdata)
  );

  // Id and owner of each slot.
  tsr_ram #(.W(A_W), .DEPTH(SLOTS)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (a_wdata),
    .raddr (raddr),
    .rdata (a_rdata)
  );

  // Commit number and generation stamp of each slot.
  tsr_ram #(.W(B_W), .DEPTH(SLOTS)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (b_wdata),
    .raddr (raddr),
    .rdata (b_rdata)
  );

  // Output register: a result beat waits here while the controller moves on.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_txn_id    = out_r.txn_id;
  assign out_slot      = out_r.slot;
  assign out_gen       = out_r.gen;
  assign out_commit_no = out_r.commit_no;
  assign out_tally     = out_r.tally;
  assign out_next_id   = out_r.next_id;
  assign out_lowest    = out_r.lowest;
  assign out_listed_id = out_r.listed_id;
  assign out_last      = out_r.last;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import tsr_pkg::*;

  localparam int TABLE_N   = 32;
  localparam int IDLE_PCT  = 31;
  localparam int STALL_MAX = 4000;

  // One command beat as driven on the input channel.
  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] owner;
    logic [63:0] txn_id;
    logic [63:0] commit_no;
    logic [5:0]  slot;
    logic [63:0] slot_gen;
    logic [5:0]  capacity;
  } cmd_beat_t;

  // Mirror of the slot table; works out the result beats each command causes.
  class slot_table_scoreboard;
    bit          active [TABLE_N];
    logic [63:0] txn    [TABLE_N];
    logic [31:0] owner  [TABLE_N];
    logic [63:0] commit [TABLE_N];
    logic [63:0] stamp  [TABLE_N];
    logic [63:0] id_counter, global_gen, oldest, start_id;
    logic [5:0]  slots_in_use;
    int          active_total;
    res_t        expected_q[$];
    int          errors;

    function new();
      slots_in_use = SIU_RST;
      start_id     = START_ID_RST;
      errors       = 0;
      clear_table();
      id_counter = start_id;
    endfunction

    function void clear_table();
      for (int i = 0; i < TABLE_N; i++) begin
        active[i] = 0; txn[i] = '0; owner[i] = '0; commit[i] = '0; stamp[i] = '0;
      end
      global_gen   = '0;
      active_total = 0;
      oldest       = '0;
    endfunction

    function int scanned();
      return (slots_in_use > TABLE_N) ? TABLE_N : int'(slots_in_use);
    endfunction

    function void write_reg(logic idx, logic [63:0] d);
      if (idx == CFG_SLOTS_IN_USE) slots_in_use = d[5:0];
      else start_id = d;
    endfunction

    function void refresh_oldest();
      logic [63:0] best;
      best = '0;
      for (int i = 0; i < scanned(); i++)
        if (active[i] && (best == 0 || txn[i] < best)) best = txn[i];
      oldest = best;
    endfunction

    function int find_txn(logic [63:0] id);
      for (int i = 0; i < scanned(); i++)
        if (active[i] && txn[i] == id) return i;
      return -1;
    endfunction

    function void retire_slot(int i);
      global_gen = global_gen + 1;
      active[i] = 0; txn[i] = '0; owner[i] = '0; commit[i] = '0;
      stamp[i] = global_gen;
      active_total--;
    endfunction

    // Listing of active ids for snapshot and read view.
    function void list_ids(logic [5:0] cap, bit read_view);
      res_t        r;
      logic [63:0] low;
      logic [63:0] ids[$];
      r = '0;
      if (read_view) begin
        low = id_counter;
        for (int i = 0; i < scanned(); i++)
          if (active[i] && commit[i] < low) low = commit[i];
      end else begin
        low = oldest;
      end
      r.tally = active_total[5:0]; r.next_id = id_counter; r.lowest = low; r.last = 1;
      if (active_total > cap) begin
        r.status = ST_FULL;
        expected_q.push_back(r);
        return;
      end
      for (int i = 0; i < scanned(); i++)
        if (active[i]) ids.push_back(txn[i]);
      if (ids.size() != active_total) begin
        r = '0; r.status = ST_ERROR; r.last = 1;
        expected_q.push_back(r);
        return;
      end
      ids.sort();
      if (ids.size() == 0) begin
        expected_q.push_back(r);
        return;
      end
      foreach (ids[k]) begin
        r.listed_id = ids[k];
        r.last = (k == ids.size() - 1);
        expected_q.push_back(r);
      end
    endfunction

    function void note_command(cmd_beat_t b);
      res_t r;
      int   s;
      int   released;
      r = '0; r.status = ST_OK; r.last = 1;
      case (b.cmd)
        CMD_BEGIN: begin
          s = 0;
          while (s < scanned() && active[s]) s++;
          if (b.owner == 0 || id_counter == ALL_ONES) r.status = ST_ERROR;
          else if (s >= scanned()) r.status = ST_FULL;
          else if (global_gen == ALL_ONES) r.status = ST_ERROR;
          else begin
            global_gen = global_gen + 1;
            active[s] = 1; txn[s] = id_counter; owner[s] = b.owner;
            commit[s] = ALL_ONES; stamp[s] = global_gen;
            active_total++;
            if (oldest == 0 || id_counter < oldest) oldest = id_counter;
            r.txn_id = id_counter; r.slot = s[4:0]; r.gen = global_gen;
            id_counter = id_counter + 1;
          end
        end
        CMD_ALLOCATE: begin
          if (id_counter == ALL_ONES) r.status = ST_ERROR;
          else begin
            r.txn_id = id_counter;
            id_counter = id_counter + 1;
          end
        end
        CMD_ASSIGN: begin
          if (b.txn_id == 0 || b.commit_no == 0 || b.commit_no == ALL_ONES)
            r.status = ST_ERROR;
          else begin
            s = find_txn(b.txn_id);
            if (s < 0) r.status = ST_NOT_FOUND;
            else commit[s] = b.commit_no;
          end
        end
        CMD_ASSIGN_NEW: begin
          s = find_txn(b.txn_id);
          if (b.txn_id == 0) r.status = ST_ERROR;
          else if (s < 0) r.status = ST_NOT_FOUND;
          else if (id_counter == ALL_ONES) r.status = ST_ERROR;
          else begin
            commit[s] = id_counter;
            r.commit_no = id_counter;
            id_counter = id_counter + 1;
          end
        end
        CMD_END: begin
          if (b.slot_gen == 0) r.status = ST_ERROR;
          else if (b.slot >= scanned() || !active[b.slot] || stamp[b.slot] != b.slot_gen)
            r.status = ST_NOT_FOUND;
          else if (global_gen == ALL_ONES || active_total == 0) r.status = ST_ERROR;
          else begin
            retire_slot(b.slot);
            refresh_oldest();
          end
        end
        CMD_RELEASE: begin
          released = 0;
          if (b.owner == 0 || global_gen > ALL_ONES - 64'(active_total)) r.status = ST_ERROR;
          else begin
            for (int i = 0; i < scanned(); i++)
              if (active[i] && owner[i] == b.owner && active_total > 0) begin
                retire_slot(i);
                released++;
              end
            if (released > 0) refresh_oldest();
            r.tally = released[5:0];
          end
        end
        CMD_SNAPSHOT: begin
          list_ids(b.capacity, 0);
          return;
        end
        CMD_READ_VIEW: begin
          list_ids(b.capacity, 1);
          return;
        end
        CMD_INIT: begin
          if (start_id == 0 || slots_in_use == 0) r.status = ST_ERROR;
          else begin
            clear_table();
            id_counter = start_id;
          end
        end
        default: r.status = ST_ERROR;
      endcase
      expected_q.push_back(r);
    endfunction

    function void report(string what, logic [63:0] exp_v, logic [63:0] got_v);
      errors++;
      if (errors <= 10)
        $display("mismatch on %s: expected %h, got %h", what, exp_v, got_v);
    endfunction

    function void check_beat(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing expected: %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.status    != e.status)    report("status", e.status, got.status);
      if (got.txn_id    != e.txn_id)    report("txn_id", e.txn_id, got.txn_id);
      if (got.slot      != e.slot)      report("slot", e.slot, got.slot);
      if (got.gen       != e.gen)       report("gen", e.gen, got.gen);
      if (got.commit_no != e.commit_no) report("commit_no", e.commit_no, got.commit_no);
      if (got.tally     != e.tally)     report("tally", e.tally, got.tally);
      if (got.next_id   != e.next_id)   report("next_id", e.next_id, got.next_id);
      if (got.lowest    != e.lowest)    report("lowest", e.lowest, got.lowest);
      if (got.listed_id != e.listed_id) report("listed_id", e.listed_id, got.listed_id);
      if (got.last      != e.last)      report("last", e.last, got.last);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0, cfg_index = 0;
  logic [63:0] cfg_data = '0;
  logic        cfg_ready, in_ready, out_valid;
  logic        in_valid = 0, out_ready = 0;
  logic [3:0]  in_command = '0;
  logic [31:0] in_owner = '0;
  logic [63:0] in_txn_id = '0, in_commit_no = '0, in_slot_gen = '0;
  logic [5:0]  in_slot = '0, in_capacity = '0;
  logic [1:0]  out_status;
  logic [63:0] out_txn_id, out_gen, out_commit_no, out_next_id, out_lowest, out_listed_id;
  logic [4:0]  out_slot;
  logic [5:0]  out_tally;
  logic        out_last;

  slot_table_scoreboard registry = new();
  cmd_beat_t            cur_beat;
  bit                   calm = 0;
  int                   quiet_cycles = 0;

  transaction_slot_registry_unit i_dut (.*);

  always #6 clk = ~clk;

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk)
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  // Beat monitor and stall watchdog.
  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (in_valid && in_ready) registry.note_command(cur_beat);
      if (out_valid && out_ready) begin
        got = '{status_t'(out_status), out_txn_id, out_slot, out_gen, out_commit_no,
                out_tally, out_next_id, out_lowest, out_listed_id, out_last};
        registry.check_beat(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_MAX) begin
        $display("tb_top: errors");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cmd_beat_t make_beat(logic [3:0] c, logic [31:0] o, logic [63:0] t,
                                          logic [63:0] cn, logic [5:0] s, logic [63:0] g,
                                          logic [5:0] cap);
    cmd_beat_t b;
    b = '{c, o, t, cn, s, g, cap};
    return b;
  endfunction

  // Send one command beat, with random idle cycles ahead of it unless calm is set.
  task automatic send(cmd_beat_t b);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 0;
      @(negedge clk);
    end
    cur_beat     = b;
    in_command   = b.cmd;
    in_owner     = b.owner;
    in_txn_id    = b.txn_id;
    in_commit_no = b.commit_no;
    in_slot      = b.slot;
    in_slot_gen  = b.slot_gen;
    in_capacity  = b.capacity;
    in_valid     = 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (registry.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [63:0] d);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = d;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    registry.write_reg(idx, d);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Random command, mostly aimed at live table entries.
  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int        r, n, pick;
    int        live[$];
    b = make_beat(4'($urandom_range(0, 15)), $urandom, {$urandom, $urandom},
                  {$urandom, $urandom}, 6'($urandom_range(0, 63)), {$urandom, $urandom},
                  6'($urandom_range(0, 63)));
    n = registry.scanned();
    for (int i = 0; i < n; i++) if (registry.active[i]) live.push_back(i);
    pick = (live.size() > 0) ? live[$urandom_range(0, live.size() - 1)] : 0;
    r = $urandom_range(0, 99);
    if (r < 26) begin
      b.cmd = CMD_BEGIN;
      if ($urandom_range(0, 9) != 0) b.owner = $urandom_range(1, 4);
    end else if (r < 31) b.cmd = CMD_ALLOCATE;
    else if (r < 41 || r < 48) begin
      b.cmd = (r < 41) ? CMD_ASSIGN : CMD_ASSIGN_NEW;
      if (live.size() > 0 && $urandom_range(0, 9) != 0) b.txn_id = registry.txn[pick];
      if ($urandom_range(0, 9) != 0) b.commit_no = 64'($urandom_range(1, 1000));
    end else if (r < 62) begin
      b.cmd = CMD_END;
      if (live.size() > 0 && $urandom_range(0, 6) != 0) begin
        b.slot = 6'(pick);
        b.slot_gen = registry.stamp[pick];
      end
    end else if (r < 68) begin
      b.cmd = CMD_RELEASE;
      if ($urandom_range(0, 9) != 0) b.owner = $urandom_range(1, 4);
    end else if (r < 86) begin
      b.cmd = (r < 78) ? CMD_SNAPSHOT : CMD_READ_VIEW;
      if ($urandom_range(0, 4) != 0)
        b.capacity = 6'($urandom_range(registry.active_total, 32));
    end else if (r < 88) b.cmd = CMD_INIT;
    else if (r < 91) b.cmd = 4'($urandom_range(9, 15));
    return b;
  endfunction

  task automatic random_run(int count);
    for (int k = 0; k < count; k++) send(random_beat());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed opening under the reset settings.
    send(make_beat(CMD_BEGIN, 0, 0, 0, 0, 0, 0));
    send(make_beat(CMD_BEGIN, 7, 0, 0, 0, 0, 0));
    send(make_beat(CMD_BEGIN, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    send(make_beat(CMD_BEGIN, 7, 0, 0, 0, 0, 0));
    send(make_beat(CMD_ALLOCATE, 0, 0, 0, 0, 0, 0));
    send(make_beat(CMD_ASSIGN, 0, 0, 5, 0, 0, 0));
    send(make_beat(CMD_ASSIGN, 0, 2, 0, 0, 0, 0));
    send(make_beat(CMD_ASSIGN, 0, 2, ALL_ONES, 0, 0, 0));
    send(make_beat(CMD_ASSIGN, 0, 2, 100, 0, 0, 0));
    send(make_beat(CMD_ASSIGN, 0, ALL_ONES, 5, 0, 0, 0));
    send(make_beat(CMD_ASSIGN_NEW, 0, 3, 0, 0, 0, 0));
    send(make_beat(CMD_ASSIGN_NEW, 0, 0, 0, 0, 0, 0));
    send(make_beat(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 1));
    send(make_beat(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 63));
    send(make_beat(CMD_READ_VIEW, 0, 0, 0, 0, 0, 32));
    send(make_beat(CMD_END, 0, 0, 0, 1, 0, 0));
    send(make_beat(CMD_END, 0, 0, 0, 63, 1, 0));
    send(make_beat(CMD_END, 0, 0, 0, 1, ALL_ONES, 0));
    send(make_beat(CMD_END, 0, 0, 0, 1, 2, 0));
    send(make_beat(CMD_RELEASE, 0, 0, 0, 0, 0, 0));
    send(make_beat(CMD_RELEASE, 7, 0, 0, 0, 0, 0));
    send(make_beat(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 0));
    send(make_beat(4'd9, 0, 0, 0, 0, 0, 0));
    send(make_beat(4'd15, 0, 0, 0, 0, 0, 0));
    send(make_beat(CMD_INIT, 0, 0, 0, 0, 0, 0));

    // Random traffic on the full table; the first stretch runs without idling.
    calm = 1;
    random_run(60);
    calm = 0;
    random_run(40);
    drain();
    random_run(40);

    // Shrunken table: entries beyond the scan stay active until initialise.
    drain();
    write_reg(CFG_SLOTS_IN_USE, 5);
    write_reg(CFG_START_ID, {$urandom, $urandom});
    send(make_beat(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 32));
    send(make_beat(CMD_READ_VIEW, 0, 0, 0, 0, 0, 32));
    send(make_beat(CMD_INIT, 0, 0, 0, 0, 0, 0));
    random_run(45);

    // Counters near their top end.
    drain();
    write_reg(CFG_START_ID, ALL_ONES - 2);
    send(make_beat(CMD_INIT, 0, 0, 0, 0, 0, 0));
    send(make_beat(CMD_BEGIN, 3, 0, 0, 0, 0, 0));
    send(make_beat(CMD_ASSIGN_NEW, 0, ALL_ONES - 2, 0, 0, 0, 0));
    send(make_beat(CMD_BEGIN, 3, 0, 0, 0, 0, 0));
    send(make_beat(CMD_ALLOCATE, 0, 0, 0, 0, 0, 0));
    send(make_beat(CMD_ASSIGN_NEW, 0, ALL_ONES - 2, 0, 0, 0, 0));
    send(make_beat(CMD_READ_VIEW, 0, 0, 0, 0, 0, 32));

    // Zero registers make initialise fail; an empty scan leaves begin full.
    drain();
    write_reg(CFG_START_ID, 0);
    send(make_beat(CMD_INIT, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(CFG_START_ID, 1);
    send(make_beat(CMD_INIT, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(CFG_SLOTS_IN_USE, 0);
    send(make_beat(CMD_INIT, 0, 0, 0, 0, 0, 0));
    send(make_beat(CMD_BEGIN, 1, 0, 0, 0, 0, 0));
    send(make_beat(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 32));

    // Single slot, then the widest register value.
    drain();
    write_reg(CFG_SLOTS_IN_USE, 1);
    send(make_beat(CMD_INIT, 0, 0, 0, 0, 0, 0));
    random_run(30);
    drain();
    write_reg(CFG_SLOTS_IN_USE, 63);
    write_reg(CFG_START_ID, 1000);
    send(make_beat(CMD_INIT, 0, 0, 0, 0, 0, 0));
    random_run(25);

    drain();
    repeat (100) @(posedge clk);
    if (registry.errors == 0 && registry.expected_q.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/tsr_pkg.sv
sv/tsr_ram.sv
sv/tsr_ctrl.sv
sv/transaction_slot_registry_unit.sv
tb/tb_top.sv
